// ===== rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the segment crossing test
// Coordinate, difference and fixed-point length widths, payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sct_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 12;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int RAD_W      = PROD_W + 2 * FRAC_BITS;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SLACK_W    = ROOT_W + 2;
  localparam int TOL_W      = 12;
  localparam int NUM_LEN    = 6;
  localparam int NUM_ORI    = 4;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(205);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic [ROOT_W-1:0]            root_t;

  typedef struct packed {
    coord_t seg1_start_x;
    coord_t seg1_start_y;
    coord_t seg1_end_x;
    coord_t seg1_end_y;
    coord_t seg2_start_x;
    coord_t seg2_start_y;
    coord_t seg2_end_x;
    coord_t seg2_end_y;
  } sct_in_t;

  typedef struct packed {
    logic crossing;
  } sct_out_t;

  typedef struct packed {
    diff_t x;
    diff_t y;
  } vec_t;

  // vector from point p to point q, exact
  function automatic vec_t vsub(coord_t px, coord_t py, coord_t qx, coord_t qy);
    vec_t v;
    v.x = DIFF_W'(qx) - DIFF_W'(px);
    v.y = DIFF_W'(qy) - DIFF_W'(py);
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sct_in_if.sv =====
// ----------------------------------------------------------------------------
// sct_in_if: segment pair request channel
// Valid/ready channel carrying the eight endpoint coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface sct_in_if;
  logic             valid;
  logic             ready;
  sct_pkg::sct_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sct_out_if.sv =====
// ----------------------------------------------------------------------------
// sct_out_if: crossing result channel
// Valid/ready channel carrying one crossing flag per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sct_out_if;
  logic              valid;
  logic              ready;
  sct_pkg::sct_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sct_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sct_cfg_if: tolerance register write channel
// Valid/ready channel carrying the near-touch tolerance write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sct_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sct_pkg::TOL_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sct_sqrt.sv =====
// ----------------------------------------------------------------------------
// sct_sqrt: pipelined integer square root
// One root digit per register stage, restoring method, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module sct_sqrt (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [sct_pkg::RAD_W-1:0]   rad_i,
  output sct_pkg::root_t                   root_o
);

  localparam int RW = sct_pkg::RAD_W;
  localparam int NW = sct_pkg::ROOT_W;
  localparam int MW = sct_pkg::REM_W;

  logic [RW-1:0] x_q    [NW-1];
  logic [MW-1:0] rem_q  [NW];
  logic [NW-1:0] root_q [NW];

  for (genvar g = 0; g < NW; g++) begin : g_dig
    logic [RW-1:0] x_in;
    logic [MW-1:0] rem_in, rem_sh, trial, rem_d;
    logic [NW-1:0] root_in, root_d;

    if (g == 0) begin : g_first
      assign x_in    = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
    end

    always_comb begin
      rem_sh = {rem_in[MW-3:0], x_in[RW-1:RW-2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_in[NW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_in[NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
      end
    end

    if (g < NW - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[g] <= {x_in[RW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[NW-1];

endmodule

`default_nettype wire

// ===== rtl/segment_crossing_test_core.sv =====
// ----------------------------------------------------------------------------
// segment_crossing_test_core: proper crossing test of two line segments
// Near-touch rejection by fixed-point lengths, combined with exact orientation signs.
// ----------------------------------------------------------------------------
// Usage:
//   seg_in  : one request per segment pair (A, B, C, D coordinates).
//   res_out : one crossing flag per request, in request order.
//   cfg_in  : writes the near-touch tolerance (always ready); write it only
//             while no request is in flight.
// Requests pass through 3 arithmetic stages, 29 root digit stages and one
// slack and decision stage. Throughput is one request per cycle while results
// are taken: six root pipelines of one digit per stage run side by side.
// The whole pipeline advances when the result register is empty or taken;
// when the receiver stalls with a result waiting, seg_in.ready drops and all
// stages hold. Reset clears all valid bits and loads the tolerance with 205.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_crossing_test_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sct_in_if.sink    seg_in,
  sct_out_if.source res_out,
  sct_cfg_if.sink   cfg_in
);

  localparam int NW = sct_pkg::ROOT_W;
  localparam int SW = sct_pkg::SLACK_W;
  localparam int NL = sct_pkg::NUM_LEN;
  localparam int NO = sct_pkg::NUM_ORI;

  // length slots
  localparam int L_AB = 0;
  localparam int L_CD = 1;
  localparam int L_AC = 2;
  localparam int L_AD = 3;
  localparam int L_CB = 4;
  localparam int L_BD = 5;

  logic en;
  logic [sct_pkg::TOL_W-1:0] tol_q;

  // stage 1: difference vectors
  logic         v1_q;
  sct_pkg::vec_t d_ab_q, d_cd_q, d_ac_q, d_ad_q, d_ca_q, d_cb_q, d_bd_q;
  // stage 2: squares and cross products
  logic          v2_q;
  sct_pkg::prod_t sqx_q [NL];
  sct_pkg::prod_t sqy_q [NL];
  sct_pkg::prod_t prp_q [NO];
  sct_pkg::prod_t prq_q [NO];
  // stage 3: squared lengths and straddle flag
  logic          v3_q, ok3_q;
  logic [sct_pkg::PROD_W-1:0] sum_q [NL];
  // root stages
  logic [NW-1:0] vs_q, oks_q;
  sct_pkg::root_t len [NL];
  // result
  logic out_valid_q, crossing_q;

  assign en           = !out_valid_q || res_out.ready;
  assign seg_in.ready = en;
  assign cfg_in.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= sct_pkg::TOL_RESET;
    end else if (cfg_in.valid) begin
      tol_q <= cfg_in.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      vs_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= seg_in.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      vs_q        <= {vs_q[NW-2:0], v3_q};
      out_valid_q <= vs_q[NW-1];
    end
  end

  // stage 1
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_ab_q <= sct_pkg::vsub(seg_in.data.seg1_start_x, seg_in.data.seg1_start_y,
                              seg_in.data.seg1_end_x, seg_in.data.seg1_end_y);
      d_cd_q <= sct_pkg::vsub(seg_in.data.seg2_start_x, seg_in.data.seg2_start_y,
                              seg_in.data.seg2_end_x, seg_in.data.seg2_end_y);
      d_ac_q <= sct_pkg::vsub(seg_in.data.seg1_start_x, seg_in.data.seg1_start_y,
                              seg_in.data.seg2_start_x, seg_in.data.seg2_start_y);
      d_ad_q <= sct_pkg::vsub(seg_in.data.seg1_start_x, seg_in.data.seg1_start_y,
                              seg_in.data.seg2_end_x, seg_in.data.seg2_end_y);
      d_ca_q <= sct_pkg::vsub(seg_in.data.seg2_start_x, seg_in.data.seg2_start_y,
                              seg_in.data.seg1_start_x, seg_in.data.seg1_start_y);
      d_cb_q <= sct_pkg::vsub(seg_in.data.seg2_start_x, seg_in.data.seg2_start_y,
                              seg_in.data.seg1_end_x, seg_in.data.seg1_end_y);
      d_bd_q <= sct_pkg::vsub(seg_in.data.seg1_end_x, seg_in.data.seg1_end_y,
                              seg_in.data.seg2_end_x, seg_in.data.seg2_end_y);
    end
  end

  // stage 2
  sct_pkg::vec_t lv [NL];
  assign lv[L_AB] = d_ab_q;
  assign lv[L_CD] = d_cd_q;
  assign lv[L_AC] = d_ac_q;
  assign lv[L_AD] = d_ad_q;
  assign lv[L_CB] = d_cb_q;
  assign lv[L_BD] = d_bd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        sqx_q[i] <= lv[i].x * lv[i].x;
        sqy_q[i] <= lv[i].y * lv[i].y;
      end
      // orient(A,B,C), orient(A,B,D), orient(C,D,A), orient(C,D,B)
      prp_q[0] <= d_ab_q.x * d_ac_q.y;
      prq_q[0] <= d_ac_q.x * d_ab_q.y;
      prp_q[1] <= d_ab_q.x * d_ad_q.y;
      prq_q[1] <= d_ad_q.x * d_ab_q.y;
      prp_q[2] <= d_cd_q.x * d_ca_q.y;
      prq_q[2] <= d_ca_q.x * d_cd_q.y;
      prp_q[3] <= d_cd_q.x * d_cb_q.y;
      prq_q[3] <= d_cb_q.x * d_cd_q.y;
    end
  end

  // stage 3
  logic [NO-1:0] gt, lt;
  always_comb begin
    for (int i = 0; i < NO; i++) begin
      gt[i] = prp_q[i] > prq_q[i];
      lt[i] = prp_q[i] < prq_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NL; i++) begin
        sum_q[i] <= sqx_q[i] + sqy_q[i];
      end
      ok3_q <= ((gt[0] && lt[1]) || (lt[0] && gt[1])) &&
               ((gt[2] && lt[3]) || (lt[2] && gt[3]));
    end
  end

  // root stages
  for (genvar l = 0; l < NL; l++) begin : g_len
    sct_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  ({sum_q[l], {(2 * sct_pkg::FRAC_BITS){1'b0}}}),
      .root_o (len[l])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oks_q <= {oks_q[NW-2:0], ok3_q};
    end
  end

  // slack = |PU| + |PV| - |UV|; near when below tolerance
  function automatic logic is_near(sct_pkg::root_t a, sct_pkg::root_t b,
                                   sct_pkg::root_t c, logic [sct_pkg::TOL_W-1:0] t);
    logic signed [SW-1:0] slack;
    slack = $signed(SW'(a)) + $signed(SW'(b)) - $signed(SW'(c));
    return slack < $signed(SW'(t));
  endfunction

  logic [3:0] near;
  always_comb begin
    near[0] = is_near(len[L_AC], len[L_CB], len[L_AB], tol_q);
    near[1] = is_near(len[L_AD], len[L_BD], len[L_AB], tol_q);
    near[2] = is_near(len[L_AC], len[L_AD], len[L_CD], tol_q);
    near[3] = is_near(len[L_CB], len[L_BD], len[L_CD], tol_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      crossing_q <= oks_q[NW-1] && !(|near);
    end
  end

  assign res_out.valid         = out_valid_q;
  assign res_out.data.crossing = crossing_q;

  a_tol_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_in.valid |=> $stable(tol_q))
    else $error("tolerance changed without a write");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vs_q) && $stable(v3_q) && $stable(v1_q))
    else $error("pipeline moved during stall");

  a_no_straddle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && !oks_q[NW-1]) |=> !crossing_q)
    else $error("crossing reported without straddle");

  a_accept_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_out.ready) |-> !seg_in.ready)
    else $error("request taken while result stalled");

endmodule

`default_nettype wire
